FILE: sv/midi_track_event_parser_defines.svh
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MTEP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define MTEP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: sv/mtep_pkg.sv
`default_nettype none

package mtep_pkg;

  localparam int TICK_BITS = 32;
  localparam int LEN_W     = 28;

  localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_TEMPO    = 2'd2;

  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] META_TEMPO   = 8'h51;

  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_POLY_AT   = 4'hA;
  localparam logic [3:0] HI_CTRL      = 4'hB;
  localparam logic [3:0] HI_PROG      = 4'hC;
  localparam logic [3:0] HI_CHAN_AT   = 4'hD;
  localparam logic [3:0] HI_BEND      = 4'hE;

endpackage

`default_nettype wire

FILE: sv/midi_track_event_parser.sv
// Standard MIDI file track parser: takes one track-chunk byte per cycle and
// emits note-off, note-on and tempo events with their absolute tick. A byte is
// decoded in the cycle it is accepted, against the parse state registers, and
// any event it completes lands in the output register on that same edge, so it
// is offered on the next cycle. Input ready is high whenever the output
// register is empty or being taken, so with out_ready high the rate is one byte
// per cycle; the output register alone sets it. A byte marked last of track is
// decoded normally and then returns all parse state to its reset value.
`default_nettype none

`include "midi_track_event_parser_defines.svh"

module midi_track_event_parser
  import mtep_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_of_track,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [31:0]      out_event_tick,
  output logic [3:0]       out_channel,
  output logic [7:0]       out_key_number,
  output logic [7:0]       out_velocity,
  output logic [23:0]      out_tempo_us
);

  localparam logic [3:0] PH_DELTA     = 4'd0;
  localparam logic [3:0] PH_STATUS    = 4'd1;
  localparam logic [3:0] PH_META_TYPE = 4'd2;
  localparam logic [3:0] PH_META_LEN  = 4'd3;
  localparam logic [3:0] PH_SYSEX_LEN = 4'd4;
  localparam logic [3:0] PH_SKIP      = 4'd5;
  localparam logic [3:0] PH_NOTE_KEY  = 4'd6;
  localparam logic [3:0] PH_NOTE_VEL  = 4'd7;
  localparam logic [3:0] PH_TEMPO     = 4'd8;
  localparam logic [3:0] PH_HALT      = 4'd9;

  logic [3:0]           phase_r, phase_nxt;
  logic [TICK_BITS-1:0] tick_r, tick_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic [7:0]           rs_r, rs_nxt;
  logic [7:0]           meta_r, meta_nxt;
  logic [LEN_W-1:0]     skip_r, skip_nxt;
  logic [7:0]           key_r, key_nxt;
  logic [23:0]          tempo_r, tempo_nxt;

  logic                 out_valid_r;
  logic [1:0]           kind_r;
  logic [31:0]          otick_r;
  logic [3:0]           chan_r;
  logic [7:0]           okey_r, vel_r;
  logic [23:0]          otempo_r;

  logic                 emit;
  logic [1:0]           kind_nxt;
  logic [3:0]           chan_nxt;
  logic [7:0]           okey_nxt, vel_nxt;
  logic [23:0]          otempo_nxt;

  logic                 accept;
  logic [7:0]           b;
  logic [LEN_W-1:0]     len_fed;
  logic [2:0]           cnt_fed;
  logic                 vlq_done;
  logic [TICK_BITS:0]   tick_sum;
  logic [LEN_W-1:0]     skip_dec;
  logic                 is_status;
  logic [7:0]           rs_eff;
  logic [3:0]           st_hi;
  logic [LEN_W-1:0]     skip_start;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign b        = in_data_byte;

  assign len_fed  = {len_r[LEN_W-8:0], b[6:0]};
  assign cnt_fed  = cnt_r + 3'd1;
  assign vlq_done = !b[7] || (cnt_fed >= 3'd4);
  assign tick_sum = {1'b0, tick_r} + (TICK_BITS+1)'(len_fed);
  assign skip_dec = skip_r - LEN_W'(1);

  assign is_status = b[7];
  assign rs_eff    = is_status ? b : rs_r;
  assign st_hi     = rs_eff[7:4];

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    rs_nxt     = rs_r;
    meta_nxt   = meta_r;
    skip_nxt   = skip_r;
    key_nxt    = key_r;
    tempo_nxt  = tempo_r;
    emit       = 1'b0;
    kind_nxt   = KIND_NOTE_OFF;
    chan_nxt   = 4'd0;
    okey_nxt   = 8'd0;
    vel_nxt    = 8'd0;
    otempo_nxt = 24'd0;
    skip_start = '0;
    unique case (phase_r)
      PH_DELTA: begin
        len_nxt = len_fed;
        cnt_nxt = cnt_fed;
        if (vlq_done) begin
          tick_nxt  = tick_sum[TICK_BITS] ? '1 : tick_sum[TICK_BITS-1:0];
          len_nxt   = '0;
          cnt_nxt   = 3'd0;
          phase_nxt = PH_STATUS;
        end
      end
      PH_STATUS: begin
        priority if (b == ST_META) begin
          phase_nxt = PH_META_TYPE;
        end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
          len_nxt   = '0;
          cnt_nxt   = 3'd0;
          phase_nxt = PH_SYSEX_LEN;
        end else begin
          rs_nxt = rs_eff;
          priority if (st_hi == HI_NOTE_OFF || st_hi == HI_NOTE_ON) begin
            if (is_status) begin
              phase_nxt = PH_NOTE_KEY;
            end else begin
              key_nxt   = b;
              phase_nxt = PH_NOTE_VEL;
            end
          end else if (st_hi == HI_POLY_AT || st_hi == HI_CTRL || st_hi == HI_BEND) begin
            skip_start = is_status ? LEN_W'(2) : LEN_W'(1);
            skip_nxt   = skip_start;
            phase_nxt  = PH_SKIP;
          end else if (st_hi == HI_PROG || st_hi == HI_CHAN_AT) begin
            skip_start = is_status ? LEN_W'(1) : LEN_W'(0);
            skip_nxt   = skip_start;
            phase_nxt  = (skip_start == '0) ? PH_DELTA : PH_SKIP;
          end else begin
            phase_nxt = PH_HALT;
          end
        end
      end
      PH_META_TYPE: begin
        meta_nxt  = b;
        len_nxt   = '0;
        cnt_nxt   = 3'd0;
        phase_nxt = PH_META_LEN;
      end
      PH_META_LEN: begin
        len_nxt = len_fed;
        cnt_nxt = cnt_fed;
        if (vlq_done) begin
          len_nxt = '0;
          cnt_nxt = 3'd0;
          if (meta_r == META_TEMPO && len_fed == LEN_W'(3)) begin
            tempo_nxt = 24'd0;
            skip_nxt  = LEN_W'(3);
            phase_nxt = PH_TEMPO;
          end else begin
            skip_nxt  = len_fed;
            phase_nxt = (len_fed == '0) ? PH_DELTA : PH_SKIP;
          end
        end
      end
      PH_SYSEX_LEN: begin
        len_nxt = len_fed;
        cnt_nxt = cnt_fed;
        if (vlq_done) begin
          len_nxt   = '0;
          cnt_nxt   = 3'd0;
          skip_nxt  = len_fed;
          phase_nxt = (len_fed == '0) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_nxt  = skip_dec;
        phase_nxt = (skip_dec == '0) ? PH_DELTA : PH_SKIP;
      end
      PH_NOTE_KEY: begin
        key_nxt   = b;
        phase_nxt = PH_NOTE_VEL;
      end
      PH_NOTE_VEL: begin
        emit      = 1'b1;
        kind_nxt  = (rs_r[7:4] == HI_NOTE_ON && b != 8'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
        chan_nxt  = rs_r[3:0];
        okey_nxt  = key_r;
        vel_nxt   = b;
        phase_nxt = PH_DELTA;
      end
      PH_TEMPO: begin
        tempo_nxt = {tempo_r[15:0], b};
        skip_nxt  = skip_dec;
        if (skip_dec == '0) begin
          emit       = 1'b1;
          kind_nxt   = KIND_TEMPO;
          otempo_nxt = {tempo_r[15:0], b};
          phase_nxt  = PH_DELTA;
        end
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      tick_r  <= '0;
      len_r   <= '0;
      cnt_r   <= 3'd0;
      rs_r    <= 8'd0;
      meta_r  <= 8'd0;
      skip_r  <= '0;
      key_r   <= 8'd0;
      tempo_r <= 24'd0;
    end else if (accept) begin
      if (in_last_of_track) begin
        phase_r <= PH_DELTA;
        tick_r  <= '0;
        len_r   <= '0;
        cnt_r   <= 3'd0;
        rs_r    <= 8'd0;
        meta_r  <= 8'd0;
        skip_r  <= '0;
        key_r   <= 8'd0;
        tempo_r <= 24'd0;
      end else begin
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        len_r   <= len_nxt;
        cnt_r   <= cnt_nxt;
        rs_r    <= rs_nxt;
        meta_r  <= meta_nxt;
        skip_r  <= skip_nxt;
        key_r   <= key_nxt;
        tempo_r <= tempo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind_r   <= kind_nxt;
      otick_r  <= 32'(tick_r);
      chan_r   <= chan_nxt;
      okey_r   <= okey_nxt;
      vel_r    <= vel_nxt;
      otempo_r <= otempo_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_r;
  assign out_event_tick = otick_r;
  assign out_channel    = chan_r;
  assign out_key_number = okey_r;
  assign out_velocity   = vel_r;
  assign out_tempo_us   = otempo_r;

  `MTEP_ASSERT_NXT(a_track_end_clears, accept && in_last_of_track, phase_r == PH_DELTA && tick_r == '0 && rs_r == 8'd0)
  `MTEP_ASSERT_IMP(a_tempo_count, phase_r == PH_TEMPO, skip_r >= LEN_W'(1) && skip_r <= LEN_W'(3))
  `MTEP_ASSERT_IMP(a_skip_nonzero, phase_r == PH_SKIP, skip_r != '0)
  `MTEP_ASSERT_IMP(a_vlq_count, 1'b1, cnt_r <= 3'd3)
  `MTEP_ASSERT_IMP(a_tempo_fields, out_valid_r && kind_r == KIND_TEMPO, chan_r == 4'd0 && okey_r == 8'd0 && vel_r == 8'd0)

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mtep_pkg::*;

  localparam int ITEMS         = 1250;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int VLQ_MAX_BYTES = 4;
  localparam int TEMPO_LEN     = 3;
  localparam int DIR_ROWS      = 30;

  typedef enum logic [3:0] {
    AWAIT_DELTA, AWAIT_STATUS, META_TYPE, META_LEN, SYSEX_LEN,
    SKIP_DATA, NOTE_KEY, NOTE_VEL, TEMPO_DATA, HALTED
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tick;
    logic [3:0]  chan;
    logic [7:0]  key;
    logic [7:0]  vel;
    logic [23:0] tempo;
  } midi_evt_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
    logic       pin;
    midi_evt_t  ev;
  } dir_row_t;

  localparam midi_evt_t NO_EVT = '0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_of_track;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_event_kind;
  logic [31:0] out_event_tick;
  logic [3:0]  out_channel;
  logic [7:0]  out_key_number;
  logic [7:0]  out_velocity;
  logic [23:0] out_tempo_us;

  midi_track_event_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_of_track (in_last_of_track),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_event_tick   (out_event_tick),
    .out_channel      (out_channel),
    .out_key_number   (out_key_number),
    .out_velocity     (out_velocity),
    .out_tempo_us     (out_tempo_us)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // parser shadow state
  parse_phase_e         phase;
  logic [TICK_BITS-1:0] tick_total;
  logic [LEN_W-1:0]     len_acc;
  logic [2:0]           len_cnt;
  logic [7:0]           run_status;
  logic [7:0]           meta_kind;
  logic [LEN_W-1:0]     skip_left;
  logic [7:0]           held_key;
  logic [23:0]          tempo_acc;

  midi_evt_t evt_q[$];
  midi_evt_t got_ev;
  midi_evt_t want_ev;
  int        mism;
  int        cycles;
  int        words_sent;
  int        tx_burst;
  int        rx_burst;
  int        rx_wait;
  logic      sink_hold;
  logic [7:0] trk[$];
  logic [7:0] gen_rs;

  dir_row_t directed [DIR_ROWS] = '{
    '{8'h00, 1'b0, 1'b0, NO_EVT},
    '{8'h40, 1'b0, 1'b0, NO_EVT},
    '{8'hF4, 1'b1, 1'b0, NO_EVT},
    '{8'h00, 1'b0, 1'b0, NO_EVT},
    '{8'h90, 1'b0, 1'b0, NO_EVT},
    '{8'h00, 1'b0, 1'b0, NO_EVT},
    '{8'h7F, 1'b0, 1'b1, '{KIND_NOTE_ON, 32'h0, 4'h0, 8'h00, 8'h7F, 24'h0}},
    '{8'h00, 1'b0, 1'b0, NO_EVT},
    '{8'h3C, 1'b0, 1'b0, NO_EVT},
    '{8'h00, 1'b0, 1'b1, '{KIND_NOTE_OFF, 32'h0, 4'h0, 8'h3C, 8'h00, 24'h0}},
    '{8'hFF, 1'b0, 1'b0, NO_EVT},
    '{8'hFF, 1'b0, 1'b0, NO_EVT},
    '{8'hFF, 1'b0, 1'b0, NO_EVT},
    '{8'hFF, 1'b0, 1'b0, NO_EVT},
    '{8'h8F, 1'b0, 1'b0, NO_EVT},
    '{8'hFF, 1'b0, 1'b0, NO_EVT},
    '{8'hFF, 1'b0, 1'b1, '{KIND_NOTE_OFF, 32'h0FFFFFFF, 4'hF, 8'hFF, 8'hFF, 24'h0}},
    '{8'h00, 1'b0, 1'b0, NO_EVT},
    '{8'hFF, 1'b0, 1'b0, NO_EVT},
    '{8'h51, 1'b0, 1'b0, NO_EVT},
    '{8'h03, 1'b0, 1'b0, NO_EVT},
    '{8'hFF, 1'b0, 1'b0, NO_EVT},
    '{8'hFF, 1'b0, 1'b0, NO_EVT},
    '{8'hFF, 1'b0, 1'b1, '{KIND_TEMPO, 32'h0FFFFFFF, 4'h0, 8'h00, 8'h00, 24'hFFFFFF}},
    '{8'h00, 1'b0, 1'b0, NO_EVT},
    '{8'hF0, 1'b0, 1'b0, NO_EVT},
    '{8'h00, 1'b0, 1'b0, NO_EVT},
    '{8'h00, 1'b0, 1'b0, NO_EVT},
    '{8'hF1, 1'b0, 1'b0, NO_EVT},
    '{8'h00, 1'b1, 1'b0, NO_EVT}
  };

  function automatic void reset_parser();
    phase      = AWAIT_DELTA;
    tick_total = '0;
    len_acc    = '0;
    len_cnt    = '0;
    run_status = '0;
    meta_kind  = '0;
    skip_left  = '0;
    held_key   = '0;
    tempo_acc  = '0;
  endfunction

  function automatic bit vlq_take(input logic [7:0] b);
    len_acc = {len_acc[LEN_W-8:0], b[6:0]};
    len_cnt = len_cnt + 3'd1;
    return !b[7] || (len_cnt >= VLQ_MAX_BYTES);
  endfunction

  function automatic void begin_skip(input logic [LEN_W-1:0] n);
    skip_left = n;
    phase     = (n == '0) ? AWAIT_DELTA : SKIP_DATA;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic eot,
                                    output midi_evt_t ev);
    bit                   got;
    logic [TICK_BITS:0]   tick_sum;
    logic [LEN_W-1:0]     len;
    logic [3:0]           hi;
    got = 1'b0;
    ev  = NO_EVT;
    case (phase)
      AWAIT_DELTA: begin
        if (vlq_take(b)) begin
          tick_sum   = {1'b0, tick_total} + (TICK_BITS+1)'(len_acc);
          tick_total = tick_sum[TICK_BITS] ? '1 : tick_sum[TICK_BITS-1:0];
          len_acc    = '0;
          len_cnt    = '0;
          phase      = AWAIT_STATUS;
        end
      end
      AWAIT_STATUS: begin
        if (b == ST_META) begin
          phase = META_TYPE;
        end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
          len_acc = '0;
          len_cnt = '0;
          phase   = SYSEX_LEN;
        end else begin
          if (b[7]) run_status = b;
          hi = run_status[7:4];
          case (hi)
            HI_NOTE_OFF, HI_NOTE_ON: begin
              if (b[7]) begin
                phase = NOTE_KEY;
              end else begin
                held_key = b;
                phase    = NOTE_VEL;
              end
            end
            HI_POLY_AT, HI_CTRL, HI_BEND: begin_skip(b[7] ? LEN_W'(2) : LEN_W'(1));
            HI_PROG, HI_CHAN_AT:          begin_skip(b[7] ? LEN_W'(1) : LEN_W'(0));
            default:                      phase = HALTED;
          endcase
        end
      end
      META_TYPE: begin
        meta_kind = b;
        len_acc   = '0;
        len_cnt   = '0;
        phase     = META_LEN;
      end
      META_LEN: begin
        if (vlq_take(b)) begin
          len     = len_acc;
          len_acc = '0;
          len_cnt = '0;
          if (meta_kind == META_TEMPO && len == TEMPO_LEN) begin
            tempo_acc = '0;
            skip_left = LEN_W'(TEMPO_LEN);
            phase     = TEMPO_DATA;
          end else begin
            begin_skip(len);
          end
        end
      end
      SYSEX_LEN: begin
        if (vlq_take(b)) begin
          len     = len_acc;
          len_acc = '0;
          len_cnt = '0;
          begin_skip(len);
        end
      end
      SKIP_DATA: begin_skip(skip_left - 1'b1);
      NOTE_KEY: begin
        held_key = b;
        phase    = NOTE_VEL;
      end
      NOTE_VEL: begin
        ev.kind = (run_status[7:4] == HI_NOTE_ON && b != 8'h00) ? KIND_NOTE_ON
                                                                 : KIND_NOTE_OFF;
        ev.tick = 32'(tick_total);
        ev.chan = run_status[3:0];
        ev.key  = held_key;
        ev.vel  = b;
        got     = 1'b1;
        phase   = AWAIT_DELTA;
      end
      TEMPO_DATA: begin
        tempo_acc = {tempo_acc[15:0], b};
        skip_left = skip_left - 1'b1;
        if (skip_left == '0) begin
          ev.kind  = KIND_TEMPO;
          ev.tick  = 32'(tick_total);
          ev.tempo = tempo_acc;
          got      = 1'b1;
          phase    = AWAIT_DELTA;
        end
      end
      default: phase = HALTED;
    endcase
    if (eot) reset_parser();
    return got;
  endfunction

  function automatic int gap_draw(inout int burst);
    int m;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    m = $urandom_range(0, 999);
    if (m < 15) begin
      burst = $urandom_range(40, 120);
      return 0;
    end
    if (m < 550) return 0;
    if (m < 850) return $urandom_range(1, 3);
    if (m < 970) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eot, input logic pin,
                           input midi_evt_t pinned);
    int        gap;
    midi_evt_t ev;
    bit        got;
    gap = gap_draw(tx_burst);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_last_of_track <= eot;
    do @(posedge clk); while (!in_ready);
    got = parse_byte(b, eot, ev);
    if (pin) evt_q.push_back(pinned);
    else if (got) evt_q.push_back(ev);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic put_delta(input bit big);
    int         n;
    int         m;
    logic [7:0] b;
    m = $urandom_range(0, 99);
    if (big) n = VLQ_MAX_BYTES;
    else if (m < 70) n = 1;
    else if (m < 90) n = $urandom_range(2, 3);
    else n = VLQ_MAX_BYTES;
    for (int i = 0; i < n; i++) begin
      b = big ? 8'h7F : 8'($urandom_range(0, 127));
      if (i < n - 1) b[7] = 1'b1;
      else if (n == VLQ_MAX_BYTES) b[7] = 1'($urandom_range(0, 1));
      trk.push_back(b);
    end
  endtask

  task automatic put_len(input int len);
    if (len < 128 && $urandom_range(0, 4) != 0) begin
      trk.push_back(8'(len));
    end else begin
      trk.push_back({1'b1, 7'(len >> 7)});
      trk.push_back({1'b0, 7'(len)});
    end
  endtask

  task automatic put_bytes(input int n);
    for (int i = 0; i < n; i++) trk.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_chan(input logic [3:0] hi);
    int         n;
    bit         running;
    logic [7:0] b;
    n       = (hi == HI_PROG || hi == HI_CHAN_AT) ? 1 : 2;
    running = (gen_rs[7:4] == hi) && ($urandom_range(0, 1) == 1);
    if (!running) begin
      gen_rs = {hi, 4'($urandom_range(0, 15))};
      trk.push_back(gen_rs);
    end
    for (int i = 0; i < n; i++) begin
      b = (running && i == 0) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 255));
      if ((hi == HI_NOTE_ON || hi == HI_NOTE_OFF) && i == 1 && $urandom_range(0, 4) == 0)
        b = 8'h00;
      trk.push_back(b);
    end
  endtask

  task automatic gen_track();
    logic [3:0] hi_set [7] = '{HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CTRL,
                               HI_PROG, HI_CHAN_AT, HI_BEND};
    int         n_ev;
    int         mark;
    int         pick;
    int         len;
    bit         big;
    logic [7:0] b;
    trk.delete();
    gen_rs = 8'h00;
    mark   = 0;
    if ($urandom_range(0, 19) == 0) begin
      put_bytes($urandom_range(1, 30));
      return;
    end
    big  = ($urandom_range(0, 9) == 0);
    n_ev = big ? 20 : $urandom_range(1, 25);
    for (int e = 0; e < n_ev; e++) begin
      mark = trk.size();
      put_delta(big);
      pick = big ? $urandom_range(0, 54) : $urandom_range(0, 99);
      if (pick < 35) begin
        put_chan(hi_set[$urandom_range(0, 1)]);
      end else if (pick < 55) begin
        put_chan(hi_set[$urandom_range(2, 6)]);
      end else if (pick < 68) begin
        trk.push_back(ST_META);
        trk.push_back(META_TEMPO);
        put_len(TEMPO_LEN);
        put_bytes(TEMPO_LEN);
      end else if (pick < 81) begin
        b = 8'($urandom_range(0, 255));
        if (b == META_TEMPO) b = 8'h01;
        len = $urandom_range(0, 6);
        trk.push_back(ST_META);
        trk.push_back(b);
        put_len(len);
        put_bytes(len);
      end else if (pick < 93) begin
        len = ($urandom_range(0, 30) == 0) ? $urandom_range(128, 200) : $urandom_range(0, 6);
        trk.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
        put_len(len);
        put_bytes(len);
      end else if (pick < 96) begin
        len = $urandom_range(0, 4);
        if (len >= TEMPO_LEN) len++;
        trk.push_back(ST_META);
        trk.push_back(META_TEMPO);
        put_len(len);
        put_bytes(len);
      end else if (pick < 98) begin
        b = 8'($urandom_range(8'hF1, 8'hFE));
        if (b == ST_SYSEX_ESC) b = 8'hF6;
        trk.push_back(b);
        put_bytes($urandom_range(0, 3));
      end else begin
        put_bytes($urandom_range(1, 3));
      end
    end
    // cut the final event short
    if ($urandom_range(0, 3) == 0 && trk.size() - mark >= 2) begin
      len = $urandom_range(mark + 1, trk.size() - 1);
      while (trk.size() > len) void'(trk.pop_back());
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data_byte     = 8'h00;
    in_last_of_track = 1'b0;
    mism             = 0;
    words_sent       = 0;
    tx_burst         = 0;
    reset_parser();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i])
      send_word(directed[i].b, directed[i].eot, directed[i].pin, directed[i].ev);
    while (words_sent < ITEMS + DIR_ROWS) begin
      gen_track();
      foreach (trk[i]) send_word(trk[i], i == trk.size() - 1, 1'b0, NO_EVT);
    end
    in_valid <= 1'b0;
    while (evt_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mism == 0 && evt_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    rx_wait   = 0;
    rx_burst  = 0;
    forever begin
      @(negedge clk);
      if (!rst_n || sink_hold) begin
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
        rx_wait = gap_draw(rx_burst);
      end
    end
  end

  // hold the sink off long enough to back up the input
  initial begin
    sink_hold = 1'b0;
    while (words_sent < HOLD_AT) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_ev = '{out_event_kind, out_event_tick, out_channel, out_key_number,
                 out_velocity, out_tempo_us};
      if (evt_q.size() == 0) begin
        mism++;
        if (mism <= MAX_REPORTS)
          $display("unexpected word: kind=%0d tick=%h ch=%h key=%h vel=%h tempo=%h",
                   got_ev.kind, got_ev.tick, got_ev.chan, got_ev.key, got_ev.vel,
                   got_ev.tempo);
      end else begin
        want_ev = evt_q.pop_front();
        if (got_ev !== want_ev) begin
          mism++;
          if (mism <= MAX_REPORTS)
            $display({"mismatch: exp kind=%0d tick=%h ch=%h key=%h vel=%h tempo=%h",
                      " | got kind=%0d tick=%h ch=%h key=%h vel=%h tempo=%h"},
                     want_ev.kind, want_ev.tick, want_ev.chan, want_ev.key,
                     want_ev.vel, want_ev.tempo, got_ev.kind, got_ev.tick,
                     got_ev.chan, got_ev.key, got_ev.vel, got_ev.tempo);
        end
      end
    end
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
